>>> design/bitmap_video_scanout_core_assert.svh
// Assertion macros used by the bitmap video scanout core.
`ifndef BITMAP_VIDEO_SCANOUT_CORE_ASSERT_SVH
`define BITMAP_VIDEO_SCANOUT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap scanout check failed");

// The consequent must hold in the cycle after the antecedent.
`define BVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap scanout check failed");

`endif

>>> design/bvs_pkg.sv
// Types, constants and the palette table of the bitmap video scanout.
package bvs_pkg;

    localparam int MEM_WORDS  = 8192;
    localparam int MEM_ADDR_W = 13;
    localparam int LINE_WORDS = 32;
    localparam int WORD_BITS  = 16;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_SCAN  = 1'b1;

    localparam logic [1:0] CFG_SCROLL_PORT    = 2'd0;
    localparam logic [1:0] CFG_COLOR_MODE     = 2'd1;
    localparam logic [1:0] CFG_EXTENDED_MODEL = 2'd2;
    localparam logic [1:0] CFG_PALETTE_SELECT = 2'd3;

    localparam logic [15:0] SCROLL_PORT_RESET = 16'd728;
    localparam logic [7:0]  SCROLL_BASE       = 8'o330;
    localparam logic [7:0]  SCROLL_OFFSET     = 8'o50;
    localparam int          FULL_SCREEN_BIT   = 9;

    localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
    localparam logic [23:0] RGB_BLACK = 24'h000000;

    typedef struct packed {
        logic        opcode;
        logic [12:0] word_address;
        logic [15:0] write_data;
    } req_t;

    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic        last_of_word;
        logic        end_of_frame;
    } pix_t;

    function automatic logic [23:0] palette_color(input logic [3:0] sel, input logic [1:0] code);
        logic [23:0] c1;
        logic [23:0] c2;
        logic [23:0] c3;
        unique case (sel)
            4'd0:  begin c1 = 24'h0000FF; c2 = 24'h00FF00; c3 = 24'hFF0000; end
            4'd1:  begin c1 = 24'hFFFF00; c2 = 24'hFF00FF; c3 = 24'hFF0000; end
            4'd2:  begin c1 = 24'h00FFFF; c2 = 24'h0000FF; c3 = 24'hFF00FF; end
            4'd3:  begin c1 = 24'h00FF00; c2 = 24'h00FFFF; c3 = 24'hFFFF00; end
            4'd4:  begin c1 = 24'hFF00FF; c2 = 24'h00FFFF; c3 = 24'hFFFFFF; end
            4'd5:  begin c1 = 24'hFFFFFF; c2 = 24'hFFFFFF; c3 = 24'hFFFFFF; end
            4'd6:  begin c1 = 24'h7F0000; c2 = 24'h7F0000; c3 = 24'hFF0000; end
            4'd7:  begin c1 = 24'h00FF7F; c2 = 24'h00FF7F; c3 = 24'hFFFF00; end
            4'd8:  begin c1 = 24'hFF00FF; c2 = 24'h7F00FF; c3 = 24'h7F007F; end
            4'd9:  begin c1 = 24'h00FF7F; c2 = 24'h7F00FF; c3 = 24'h7F0000; end
            4'd10: begin c1 = 24'h00FF7F; c2 = 24'h7F007F; c3 = 24'h7F0000; end
            4'd11: begin c1 = 24'h00FFFF; c2 = 24'hFFFF00; c3 = 24'hFF0000; end
            4'd12: begin c1 = 24'hFF0000; c2 = 24'h00FF00; c3 = 24'h00FFFF; end
            4'd13: begin c1 = 24'h00FFFF; c2 = 24'hFFFF00; c3 = 24'hFFFFFF; end
            4'd14: begin c1 = 24'hFFFF00; c2 = 24'h00FF00; c3 = 24'hFFFFFF; end
            default: begin c1 = 24'h00FFFF; c2 = 24'h00FF00; c3 = 24'hFFFFFF; end
        endcase
        unique case (code)
            2'd0:    palette_color = RGB_BLACK;
            2'd1:    palette_color = c1;
            2'd2:    palette_color = c2;
            default: palette_color = c3;
        endcase
    endfunction

endpackage

>>> design/bvs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bitmap_video_scanout_core.sv
// Top level of the bitmap video scanout: video memory, scan position and pixel serialiser.
// A scan request goes through the fetch stage, the serialiser and the output register.
// One pixel leaves a cycle unless pix_ready stalls; a scan can be taken while pixels leave.
// Write requests are taken every cycle outside the clearing pass and give no pixels.
// After reset a clearing pass zeroes all 8192 words of video memory; no request is taken
// until it ends, while configuration writes are taken at once.
`include "bitmap_video_scanout_core_assert.svh"

module bitmap_video_scanout_core #(
    parameter int SCREEN_LINES       = 256,
    parameter int SMALL_SCREEN_LINES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    input  logic          req_valid,
    output logic          req_ready,
    input  bvs_pkg::req_t req_data,
    output logic          pix_valid,
    input  logic          pix_ready,
    output bvs_pkg::pix_t pix_data
);

    import bvs_pkg::*;

    logic [15:0] scroll_port_reg;
    logic        color_mode_reg;
    logic        extended_model_reg;
    logic [3:0]  palette_select_reg;

    logic                  clear_active_reg;
    logic [MEM_ADDR_W-1:0] clear_addr_reg;

    logic [7:0] scan_row_reg;
    logic [4:0] scan_col_reg;

    logic       fetch_valid_reg;
    logic [7:0] fetch_row_reg;
    logic [4:0] fetch_col_reg;
    logic       fetch_blank_reg;
    logic       fetch_eof_reg;

    logic                 ser_valid_reg;
    logic [WORD_BITS-1:0] ser_word_reg;
    logic [3:0]           ser_idx_reg;
    logic [7:0]           ser_row_reg;
    logic [4:0]           ser_col_reg;
    logic                 ser_blank_reg;
    logic                 ser_eof_reg;

    logic pix_valid_reg;
    pix_t pix_reg;
    pix_t pix_next;

    logic                  req_accept;
    logic                  scan_accept;
    logic                  write_accept;
    logic                  fetch_move;
    logic                  out_load;
    logic                  ser_fire;
    logic                  ser_done;
    logic [7:0]            scroll_raw;
    logic [7:0]            scroll_dec;
    logic [7:0]            fetch_line;
    logic                  last_col;
    logic                  last_row;
    logic                  row_blank;
    logic                  ram_we;
    logic [MEM_ADDR_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [3:0]            pal_sel;
    logic [1:0]            color_code;
    logic [23:0]           pixel_color;

    // Handshake and pipeline movement.
    assign out_load     = !pix_valid_reg || pix_ready;
    assign ser_fire     = ser_valid_reg && out_load;
    assign ser_done     = ser_fire && (ser_idx_reg == 4'd15);
    assign fetch_move   = fetch_valid_reg && (!ser_valid_reg || ser_done);
    assign req_ready    = !clear_active_reg
                          && (req_data.opcode == OP_WRITE || !fetch_valid_reg || fetch_move);
    assign req_accept   = req_valid && req_ready;
    assign scan_accept  = req_accept && (req_data.opcode == OP_SCAN);
    assign write_accept = req_accept && (req_data.opcode == OP_WRITE);

    // Scroll decode and scan address.
    assign scroll_raw = scroll_port_reg[7:0];
    assign scroll_dec = (scroll_raw >= SCROLL_BASE) ? scroll_raw - SCROLL_BASE
                                                    : scroll_raw + SCROLL_OFFSET;
    assign fetch_line = scan_row_reg + scroll_dec;
    assign last_col   = (scan_col_reg == 5'(LINE_WORDS - 1));
    assign last_row   = (scan_row_reg == 8'(SCREEN_LINES - 1));
    assign row_blank  = !scroll_port_reg[FULL_SCREEN_BIT]
                        && ({1'b0, scan_row_reg} >= 9'(SMALL_SCREEN_LINES));

    assign ram_we    = clear_active_reg || write_accept;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : req_data.word_address;
    assign ram_wdata = clear_active_reg ? '0 : req_data.write_data;

    bvs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_video_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (scan_accept),
        .raddr ({fetch_line, scan_col_reg}),
        .rdata (ram_rdata)
    );

    // Pixel formation for the pixel leaving the serialiser.
    always_comb
    begin
        pal_sel     = extended_model_reg ? palette_select_reg : 4'd0;
        color_code  = ser_word_reg[{ser_idx_reg[3:1], 1'b0} +: 2];
        pixel_color = palette_color(pal_sel, color_code);

        pix_next.pixel_x      = {ser_col_reg, ser_idx_reg};
        pix_next.pixel_y      = ser_row_reg;
        pix_next.last_of_word = (ser_idx_reg == 4'd15);
        pix_next.end_of_frame = (ser_idx_reg == 4'd15) && ser_eof_reg;
        if (ser_blank_reg)
        begin
            pix_next.pixel_rgb = RGB_BLACK;
        end
        else if (color_mode_reg)
        begin
            pix_next.pixel_rgb = pixel_color;
        end
        else
        begin
            pix_next.pixel_rgb = ser_word_reg[ser_idx_reg] ? RGB_WHITE : RGB_BLACK;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_port_reg    <= SCROLL_PORT_RESET;
            color_mode_reg     <= 1'b0;
            extended_model_reg <= 1'b0;
            palette_select_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCROLL_PORT:    scroll_port_reg    <= cfg_wdata;
                CFG_COLOR_MODE:     color_mode_reg     <= cfg_wdata[0];
                CFG_EXTENDED_MODEL: extended_model_reg <= cfg_wdata[0];
                CFG_PALETTE_SELECT: palette_select_reg <= cfg_wdata[3:0];
            endcase
        end
    end

    // Control state: clearing pass, scan position and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            scan_row_reg     <= 8'd0;
            scan_col_reg     <= 5'd0;
            fetch_valid_reg  <= 1'b0;
            ser_valid_reg    <= 1'b0;
            ser_idx_reg      <= 4'd0;
            pix_valid_reg    <= 1'b0;
        end
        else
        begin
            if (clear_active_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == MEM_ADDR_W'(MEM_WORDS - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (scan_accept)
            begin
                if (last_col)
                begin
                    scan_col_reg <= 5'd0;
                    scan_row_reg <= last_row ? 8'd0 : scan_row_reg + 8'd1;
                end
                else
                begin
                    scan_col_reg <= scan_col_reg + 5'd1;
                end
            end

            if (scan_accept)
            begin
                fetch_valid_reg <= 1'b1;
            end
            else if (fetch_move)
            begin
                fetch_valid_reg <= 1'b0;
            end

            if (fetch_move)
            begin
                ser_valid_reg <= 1'b1;
                ser_idx_reg   <= 4'd0;
            end
            else if (ser_fire)
            begin
                ser_idx_reg <= ser_idx_reg + 4'd1;
                if (ser_done)
                begin
                    ser_valid_reg <= 1'b0;
                end
            end

            if (out_load)
            begin
                pix_valid_reg <= ser_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (scan_accept)
        begin
            fetch_row_reg   <= scan_row_reg;
            fetch_col_reg   <= scan_col_reg;
            fetch_blank_reg <= row_blank;
            fetch_eof_reg   <= last_col && last_row;
        end
        if (fetch_move)
        begin
            ser_word_reg  <= ram_rdata;
            ser_row_reg   <= fetch_row_reg;
            ser_col_reg   <= fetch_col_reg;
            ser_blank_reg <= fetch_blank_reg;
            ser_eof_reg   <= fetch_eof_reg;
        end
        if (ser_fire)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_reg;

    `BVS_ASSERT_SAME(a_no_request_while_clearing, clear_active_reg, !req_ready)
    `BVS_ASSERT_SAME(a_fetch_never_overrun, scan_accept, !fetch_valid_reg || fetch_move)
    `BVS_ASSERT_NEXT(a_serialiser_feeds_output, ser_fire, pix_valid)
    `BVS_ASSERT_SAME(a_frame_end_on_word_end, pix_valid && pix_data.end_of_frame,
                     pix_data.last_of_word)
    `BVS_ASSERT_NEXT(a_clear_pass_ends,
                     clear_active_reg && (clear_addr_reg == MEM_ADDR_W'(MEM_WORDS - 1)),
                     !clear_active_reg)

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the bitmap video scanout core with its own pixel predictor.
`timescale 1ns / 1ps

module tb_top;

    import bvs_pkg::*;

    localparam int SCREEN_ROWS   = 256;
    localparam int SMALL_ROWS    = 64;
    localparam int STALL_LIMIT   = 40000;
    localparam int LONG_HOLD     = 400;
    localparam int FLUSH_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 40;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data  = '0;
    logic        pix_valid;
    logic        pix_ready = 1'b0;
    pix_t        pix_data;

    req_t        request_queue[$];
    pix_t        pending_pixels[$];
    pix_t        wanted_pixel;

    logic [15:0] vram_model [MEM_WORDS];
    logic [7:0]  scan_row_model;
    logic [4:0]  scan_col_model;
    logic [15:0] scroll_reg;
    logic        colour_reg;
    logic        extended_reg;
    logic [3:0]  palette_reg;

    logic [7:0]  gen_row;
    logic [4:0]  gen_col;

    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_armed;
    int          hold_count;
    int          quiet_cycles;
    int          error_count;
    int          pixels_checked;
    int          scans_sent;
    int          writes_sent;

    bitmap_video_scanout_core #(
        .SCREEN_LINES       (SCREEN_ROWS),
        .SMALL_SCREEN_LINES (SMALL_ROWS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] scroll_shift(input logic [15:0] port);
        logic [7:0] raw;
        raw = port[7:0];
        return (raw >= SCROLL_BASE) ? raw - SCROLL_BASE : SCROLL_OFFSET + raw;
    endfunction

    function automatic logic [23:0] palette_rgb(input logic [3:0] sel, input logic [1:0] code);
        logic [71:0] colours;
        case (sel)
            4'd0:    colours = {24'h0000FF, 24'h00FF00, 24'hFF0000};
            4'd1:    colours = {24'hFFFF00, 24'hFF00FF, 24'hFF0000};
            4'd2:    colours = {24'h00FFFF, 24'h0000FF, 24'hFF00FF};
            4'd3:    colours = {24'h00FF00, 24'h00FFFF, 24'hFFFF00};
            4'd4:    colours = {24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};
            4'd5:    colours = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
            4'd6:    colours = {24'h7F0000, 24'h7F0000, 24'hFF0000};
            4'd7:    colours = {24'h00FF7F, 24'h00FF7F, 24'hFFFF00};
            4'd8:    colours = {24'hFF00FF, 24'h7F00FF, 24'h7F007F};
            4'd9:    colours = {24'h00FF7F, 24'h7F00FF, 24'h7F0000};
            4'd10:   colours = {24'h00FF7F, 24'h7F007F, 24'h7F0000};
            4'd11:   colours = {24'h00FFFF, 24'hFFFF00, 24'hFF0000};
            4'd12:   colours = {24'hFF0000, 24'h00FF00, 24'h00FFFF};
            4'd13:   colours = {24'h00FFFF, 24'hFFFF00, 24'hFFFFFF};
            4'd14:   colours = {24'hFFFF00, 24'h00FF00, 24'hFFFFFF};
            default: colours = {24'h00FFFF, 24'h00FF00, 24'hFFFFFF};
        endcase
        if (code == 2'd0)
        begin
            return RGB_BLACK;
        end
        return colours[(3 - int'(code)) * 24 +: 24];
    endfunction

    function automatic void predict_pixels(input req_t r);
        logic [7:0]  line;
        logic [15:0] word;
        logic        blank;
        logic [3:0]  pal;
        pix_t        p;
        int          i;
        if (r.opcode == OP_WRITE)
        begin
            vram_model[r.word_address] = r.write_data;
            return;
        end
        line  = scan_row_model + scroll_shift(scroll_reg);
        word  = vram_model[{line, scan_col_model}];
        blank = !scroll_reg[FULL_SCREEN_BIT] && (int'(scan_row_model) >= SMALL_ROWS);
        pal   = extended_reg ? palette_reg : 4'd0;
        for (i = 0; i < WORD_BITS; i++)
        begin
            if (blank)
                p.pixel_rgb = RGB_BLACK;
            else if (colour_reg)
                p.pixel_rgb = palette_rgb(pal, word[2 * (i / 2) +: 2]);
            else
                p.pixel_rgb = word[i] ? RGB_WHITE : RGB_BLACK;
            p.pixel_x      = {scan_col_model, 4'd0} + 9'(i);
            p.pixel_y      = scan_row_model;
            p.last_of_word = (i == WORD_BITS - 1);
            p.end_of_frame = p.last_of_word && (int'(scan_col_model) == LINE_WORDS - 1)
                             && (int'(scan_row_model) == SCREEN_ROWS - 1);
            pending_pixels.push_back(p);
        end
        if (int'(scan_col_model) == LINE_WORDS - 1)
        begin
            scan_col_model = '0;
            scan_row_model = (int'(scan_row_model) == SCREEN_ROWS - 1) ? 8'd0
                             : scan_row_model + 8'd1;
        end
        else
        begin
            scan_col_model = scan_col_model + 5'd1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_pixels(req_data);
                if (req_data.opcode == OP_SCAN)
                    scans_sent++;
                else
                    writes_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_data  <= request_queue.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ready  <= 1'b0;
            hold_count <= 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                pixels_checked++;
                if (pending_pixels.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected pixel, expected none, actual %h",
                                 $time, pix_data);
                end
                else
                begin
                    wanted_pixel = pending_pixels.pop_front();
                    if (pix_data !== wanted_pixel)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: pixel mismatch, expected rgb %06h x %0d y %0d last %b eof %b",
                                     $time, wanted_pixel.pixel_rgb, wanted_pixel.pixel_x,
                                     wanted_pixel.pixel_y, wanted_pixel.last_of_word,
                                     wanted_pixel.end_of_frame);
                            $display("%0t: pixel mismatch, actual rgb %06h x %0d y %0d last %b eof %b",
                                     $time, pix_data.pixel_rgb, pix_data.pixel_x,
                                     pix_data.pixel_y, pix_data.last_of_word,
                                     pix_data.end_of_frame);
                        end
                    end
                end
            end
            if (hold_armed && hold_count < LONG_HOLD)
            begin
                hold_count <= hold_count + 1;
                pix_ready  <= 1'b0;
            end
            else
            begin
                pix_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (pix_valid && pix_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SCROLL_PORT:    scroll_reg   = value;
            CFG_COLOR_MODE:     colour_reg   = value[0];
            CFG_EXTENDED_MODEL: extended_reg = value[0];
            default:            palette_reg  = value[3:0];
        endcase
    endtask

    task automatic set_display(input logic [15:0] scroll, input logic colour,
                               input logic ext, input logic [3:0] pal);
        write_reg(CFG_SCROLL_PORT, scroll);
        write_reg(CFG_COLOR_MODE, {15'($urandom), colour});
        write_reg(CFG_EXTENDED_MODEL, {15'($urandom), ext});
        write_reg(CFG_PALETTE_SELECT, {12'($urandom), pal});
    endtask

    task automatic push_write(input logic [12:0] addr, input logic [15:0] value);
        req_t r;
        r.opcode       = OP_WRITE;
        r.word_address = addr;
        r.write_data   = value;
        request_queue.push_back(r);
    endtask

    task automatic push_line_write(input logic [15:0] value);
        logic [7:0] line;
        line = gen_row + scroll_shift(scroll_reg);
        push_write({line, gen_col}, value);
    endtask

    task automatic push_scan();
        req_t r;
        r.opcode       = OP_SCAN;
        r.word_address = 13'($urandom);
        r.write_data   = 16'($urandom);
        request_queue.push_back(r);
        if (int'(gen_col) == LINE_WORDS - 1)
        begin
            gen_col = '0;
            gen_row = gen_row + 8'd1;
        end
        else
        begin
            gen_col = gen_col + 5'd1;
        end
    endtask

    function automatic logic [15:0] pattern_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h5555;
            3:       return 16'hAAAA;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random(input int n);
        int pushed;
        int pick;
        pushed = 0;
        while (pushed < n)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                push_line_write(pattern_word());
                push_scan();
                pushed += 2;
            end
            else if (pick < 65)
            begin
                push_scan();
                pushed++;
            end
            else
            begin
                push_write(13'($urandom), pattern_word());
                pushed++;
            end
        end
    endtask

    task automatic drain(input int extra);
        do
            @(posedge clk);
        while (request_queue.size() != 0 || req_valid || pending_pixels.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(negedge clk);
        push_random(n);
        drain(FLUSH_CYCLES);
    endtask

    initial
    begin
        foreach (vram_model[k])
            vram_model[k] = '0;
        scan_row_model = '0;
        scan_col_model = '0;
        scroll_reg     = SCROLL_PORT_RESET;
        colour_reg     = 1'b0;
        extended_reg   = 1'b0;
        palette_reg    = '0;
        gen_row        = '0;
        gen_col        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b0;
        quiet_cycles   = 0;
        error_count    = 0;
        pixels_checked = 0;
        scans_sent     = 0;
        writes_sent    = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Power-up settings first: mono, full screen, zero scroll.
        @(negedge clk);
        push_scan();
        push_line_write(16'hFFFF);
        push_scan();
        push_line_write(16'h8001);
        push_scan();
        push_write(13'h1FFF, 16'hFFFF);
        push_write(13'h0000, 16'hFFFF);
        drain(FLUSH_CYCLES);

        // Lowest raw scroll on the small screen, palette ignored without the extended model.
        set_display(16'h0000, 1'b1, 1'b0, 4'd15);
        @(negedge clk);
        push_line_write(16'hE4E4);
        push_scan();
        push_line_write(16'hFFFF);
        push_scan();
        drain(FLUSH_CYCLES);

        set_display(16'hFFFF, 1'b1, 1'b1, 4'd15);
        @(negedge clk);
        push_line_write(16'h1B1B);
        push_scan();
        push_line_write(16'hAAAA);
        push_scan();
        drain(FLUSH_CYCLES);

        // Raw scroll just below the base wraps the fetched line.
        set_display({8'h02, 8'o327}, 1'b0, 1'b1, 4'd0);
        @(negedge clk);
        push_line_write(16'h0F0F);
        push_scan();
        push_scan();
        push_line_write(16'h7FFE);
        push_scan();
        drain(FLUSH_CYCLES);

        set_display(16'($urandom) | 16'h0200, 1'b1, 1'b1, 4'($urandom));
        random_phase(90, 0, 0);
        set_display(16'($urandom), 1'b0, 1'b0, 4'($urandom));
        random_phase(90, 47, 0);
        set_display(16'($urandom), 1'b1, 1'b1, 4'($urandom));
        random_phase(90, 0, 47);
        set_display(16'($urandom), 1'b1, 1'b0, 4'($urandom));
        random_phase(90, 27, 27);

        // The receiver holds off while requests keep coming, so the core backs up.
        set_display(16'($urandom), 1'($urandom), 1'b1, 4'($urandom));
        hold_armed = 1'b1;
        random_phase(40, 0, 10);

        $display("Summary: %0d scan and %0d write requests, %0d pixels checked.",
                 scans_sent, writes_sent, pixels_checked);
        $display("Mono and palette colour, scroll extremes, idle and stall phases, long hold.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
